// File: rtl/tfes_pkg.sv
// Shared types, constants and saturation helpers for the two-fiber stress core.
`default_nettype none

package tfes_pkg;

    typedef struct packed {
        logic signed [31:0] c_xx;
        logic signed [31:0] c_xy;
        logic signed [31:0] c_yx;
        logic signed [31:0] c_yy;
    } t_stress_in;

    typedef struct packed {
        logic signed [31:0] s_xx;
        logic signed [31:0] s_shear;
        logic signed [31:0] s_yy;
        logic               saturated;
    } t_stress_out;

    typedef enum logic [2:0] {
        CFG_GAIN     = 3'd0,
        CFG_EXPONENT = 3'd1,
        CFG_OFFSET   = 3'd2,
        CFG_DIR1_COS = 3'd3,
        CFG_DIR1_SIN = 3'd4,
        CFG_DIR2_COS = 3'd5,
        CFG_DIR2_SIN = 3'd6
    } t_cfg_idx;

    localparam logic signed [25:0] DIR_COS_RESET = 26'sd16777216;

    // exponential argument limit, in whole units
    localparam int EXP_LIM = 20;
    localparam logic signed [31:0] LN2_Q30   = 32'sd744261118;
    localparam logic signed [31:0] LOG2E_Q28 = 32'sd387270501;

    // exp datapath widths
    localparam int X30W = 36;   // argument in Q30
    localparam int NW   = 6;    // power-of-two exponent
    localparam int RW   = 33;   // reduced argument
    localparam int PW   = 34;   // Horner accumulator
    localparam int VW   = 35;   // product after Q30 renormalize
    localparam int MAGW = 33;   // magnitude into constant divider
    localparam int DIV_S = 36;  // reciprocal scale, exact for MAGW-bit dividends
    localparam int DIV_MW = 37;
    localparam logic signed [PW-1:0] ONE30 = 34'sd1073741824;

    // ceil(2^36 / k) for k = 7 down to 1
    localparam logic [DIV_MW-1:0] DIV_RECIP [7] = '{
        37'd9817068106,
        37'd11453246123,
        37'd13743895348,
        37'd17179869184,
        37'd22906492246,
        37'd34359738368,
        37'd68719476736
    };

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic logic over32(input logic signed [63:0] v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (v > SAT_MAX) c = SAT_MAX;
        if (v < SAT_MIN) c = SAT_MIN;
        return 32'(c);
    endfunction

endpackage

`default_nettype wire

// File: rtl/two_fiber_exponential_stress_2d_core.sv
// Top level: configuration registers, pipeline control and two fiber families.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------
//  input    | i_in_valid / o_in_ready     | i_in_data  (t_stress_in)
//  output   | o_out_valid / i_out_ready   | o_out_data (t_stress_out)
//  config   | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One tensor per cycle when not stalled or held off by config; 6 strain/argument
// stages, 17 in the exponential (reduction, seven two-stage Horner steps, scale),
// 1 fiber product, 2 output mix. All stages advance together while the output
// register is empty or its beat is taken; a stall freezes the whole pipe.
// A config beat waits for an empty pipe and holds off input while pending.
// Synchronous active-low reset clears valid bits and restores register defaults.
`default_nettype none

module two_fiber_exponential_stress_2d_core #(
    parameter int FRAC_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tfes_pkg::t_stress_in  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tfes_pkg::t_stress_out o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    import tfes_pkg::*;

    localparam int MW = FRAC_BITS + 2;
    localparam int PIPE_DEPTH = 26;

    logic signed [31:0] r_gain, r_expo, r_offs;
    logic signed [25:0] r_d1c, r_d1s, r_d2c, r_d2s;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic w_en;

    logic signed [31:0] w_dw1, w_dw2;
    logic signed [MW-1:0] w_m1 [3];
    logic signed [MW-1:0] w_m2 [3];
    logic w_sat1, w_sat2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
            r_expo <= '0;
            r_offs <= '0;
            r_d1c  <= DIR_COS_RESET;
            r_d1s  <= '0;
            r_d2c  <= DIR_COS_RESET;
            r_d2s  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN:     r_gain <= $signed(i_cfg_data);
                CFG_EXPONENT: r_expo <= $signed(i_cfg_data);
                CFG_OFFSET:   r_offs <= $signed(i_cfg_data);
                CFG_DIR1_COS: r_d1c  <= $signed(i_cfg_data[25:0]);
                CFG_DIR1_SIN: r_d1s  <= $signed(i_cfg_data[25:0]);
                CFG_DIR2_COS: r_d2c  <= $signed(i_cfg_data[25:0]);
                CFG_DIR2_SIN: r_d2s  <= $signed(i_cfg_data[25:0]);
                default: begin
                end
            endcase
        end
    end

    // registers feed several stages, so only write with nothing in flight
    assign o_cfg_ready = ~|r_vld;

    assign w_en       = !r_vld[PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready = w_en && !i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid && o_in_ready};
        end
    end

    tfes_family #(
        .FRAC_BITS(FRAC_BITS)
    ) u_fam1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_in  (i_in_data),
        .i_cos (r_d1c),
        .i_sin (r_d1s),
        .i_gain(r_gain),
        .i_expo(r_expo),
        .i_offs(r_offs),
        .o_dw  (w_dw1),
        .o_m0  (w_m1[0]),
        .o_m1  (w_m1[1]),
        .o_m2  (w_m1[2]),
        .o_sat (w_sat1)
    );

    tfes_family #(
        .FRAC_BITS(FRAC_BITS)
    ) u_fam2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_in  (i_in_data),
        .i_cos (r_d2c),
        .i_sin (r_d2s),
        .i_gain(r_gain),
        .i_expo(r_expo),
        .i_offs(r_offs),
        .o_dw  (w_dw2),
        .o_m0  (w_m2[0]),
        .o_m1  (w_m2[1]),
        .o_m2  (w_m2[2]),
        .o_sat (w_sat2)
    );

    tfes_mix #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mix (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_dw1 (w_dw1),
        .i_dw2 (w_dw2),
        .i_m1  (w_m1),
        .i_m2  (w_m2),
        .i_sat1(w_sat1),
        .i_sat2(w_sat2),
        .o_out (o_out_data)
    );

    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && !i_cfg_valid) |-> o_in_ready)
        else $error("pipe refuses input with empty output stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted beat did not enter the pipe");

    a_idle_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && !i_in_valid) |=> !r_vld[0])
        else $error("pipe invented a beat");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_vld))
        else $error("valid bits moved during output stall");

endmodule

`default_nettype wire

// File: rtl/tfes_exp.sv
// Pipelined fixed-point exponential: range reduction, seven Horner steps, 2^n scale.
`default_nettype none

module tfes_exp #(
    parameter int FRAC_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [FRAC_BITS+5:0] i_x,
    output logic signed [31:0]        o_e,
    output logic                      o_sat
);
    import tfes_pkg::*;

    localparam int STEPS = 7;

    logic signed [X30W-1:0] n_x30;
    logic signed [65:0]     n_nprod;
    logic signed [X30W-1:0] r_x30;
    logic signed [NW-1:0]   r_n0;
    logic signed [36:0]     n_r;
    logic signed [RW-1:0]   r_r0;
    logic signed [NW-1:0]   r_n1;

    logic [MAGW-1:0]        r_mag [STEPS];
    logic                   r_neg [STEPS];
    logic signed [RW-1:0]   r_ra  [STEPS];
    logic signed [NW-1:0]   r_na  [STEPS];
    logic signed [PW-1:0]   r_p   [STEPS];
    logic signed [RW-1:0]   r_rb  [STEPS];
    logic signed [NW-1:0]   r_nb  [STEPS];

    logic signed [7:0]      n_s;
    logic signed [63:0]     n_pe;
    logic signed [63:0]     n_sh;
    logic signed [31:0]     r_e;
    logic                   r_sat;

    // range reduction: x = n*ln2 + r
    assign n_x30   = X30W'(i_x) <<< (30 - FRAC_BITS);
    assign n_nprod = 66'(n_x30) * 66'(LOG2E_Q28);
    assign n_r     = 37'(r_x30) - 37'(r_n0) * 37'(LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x30 <= n_x30;
            r_n0  <= $signed(n_nprod[63:58]);
            r_r0  <= RW'(n_r);
            r_n1  <= r_n0;
        end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic signed [PW-1:0]    p_in;
        logic signed [RW-1:0]    rr_in;
        logic signed [NW-1:0]    nn_in;
        logic signed [PW+RW-1:0] prod;
        logic signed [VW-1:0]    v;
        logic signed [VW-1:0]    v_abs;
        logic [MAGW+DIV_MW-1:0]  qprod;
        logic signed [PW-1:0]    q;

        if (j == 0) begin : g_first
            assign p_in  = ONE30;
            assign rr_in = r_r0;
            assign nn_in = r_n1;
        end else begin : g_next
            assign p_in  = r_p[j-1];
            assign rr_in = r_rb[j-1];
            assign nn_in = r_nb[j-1];
        end

        assign prod  = (PW+RW)'(p_in) * (PW+RW)'(rr_in);
        assign v     = $signed(prod[VW+29:30]);
        assign v_abs = v[VW-1] ? -v : v;
        // truncating divide by k through an exact reciprocal
        assign qprod = (MAGW+DIV_MW)'(r_mag[j]) * (MAGW+DIV_MW)'(DIV_RECIP[j]);
        assign q     = $signed({1'b0, qprod[DIV_S+MAGW-1:DIV_S]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mag[j] <= v_abs[MAGW-1:0];
                r_neg[j] <= v[VW-1];
                r_ra[j]  <= rr_in;
                r_na[j]  <= nn_in;
                r_p[j]   <= r_neg[j] ? (ONE30 - q) : (ONE30 + q);
                r_rb[j]  <= r_ra[j];
                r_nb[j]  <= r_na[j];
            end
        end
    end

    // scale by 2^n into Q.F
    assign n_s  = 8'(30 - FRAC_BITS) - 8'(r_nb[STEPS-1]);
    assign n_pe = 64'(r_p[STEPS-1]);

    always_comb begin
        if (!n_s[7]) begin
            n_sh = n_pe >>> n_s[5:0];
        end else begin
            n_sh = n_pe <<< 6'(-n_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e   <= sat32(n_sh);
            r_sat <= over32(n_sh);
        end
    end

    assign o_e   = r_e;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

// File: rtl/tfes_family.sv
// One fiber family: structural tensor, strain, exponential and fiber stress scalar.
`default_nettype none

module tfes_family #(
    parameter int FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  tfes_pkg::t_stress_in        i_in,
    input  logic signed [25:0]          i_cos,
    input  logic signed [25:0]          i_sin,
    input  logic signed [31:0]          i_gain,
    input  logic signed [31:0]          i_expo,
    input  logic signed [31:0]          i_offs,
    output logic signed [31:0]          o_dw,
    output logic signed [FRAC_BITS+1:0] o_m0,
    output logic signed [FRAC_BITS+1:0] o_m1,
    output logic signed [FRAC_BITS+1:0] o_m2,
    output logic                        o_sat
);
    import tfes_pkg::*;

    localparam int MW = FRAC_BITS + 2;
    localparam int XW = FRAC_BITS + 6;
    localparam int EXP_DEPTH = 17;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] XLIM = 64'(EXP_LIM) <<< FRAC_BITS;

    logic signed [25:0] n_cc, n_ss;
    logic signed [51:0] n_mxx, n_mxy, n_myy;
    logic signed [MW-1:0] r_m0, r_m1, r_m2;
    logic signed [31:0] r_cxx, r_cyy;
    logic signed [32:0] r_csum;

    logic signed [63:0] n_pa, n_pc;
    logic signed [65:0] n_pb;
    logic signed [33:0] r_pa, r_pb, r_pc;

    logic signed [35:0] n_i;
    logic signed [31:0] r_ic;
    logic               r_f3;

    logic signed [63:0] n_t, n_g;
    logic signed [31:0] r_t, r_g4;
    logic               r_f4;

    logic signed [63:0] r_xp;
    logic signed [31:0] r_g5;
    logic               r_f5;

    logic signed [63:0] n_xs;
    logic signed [XW-1:0] r_x;
    logic signed [31:0] r_g6;
    logic               r_f6;

    logic signed [31:0] r_gd [EXP_DEPTH];
    logic               r_fd [EXP_DEPTH];
    logic signed [31:0] w_e;
    logic               w_esat;

    logic signed [63:0] n_dw;
    logic signed [31:0] r_dw;
    logic               r_sat;

    always_comb begin
        n_cc = i_cos;
        if (32'(i_cos) > ONE) n_cc = 26'(ONE);
        if (32'(i_cos) < -ONE) n_cc = 26'(-ONE);
        n_ss = i_sin;
        if (32'(i_sin) > ONE) n_ss = 26'(ONE);
        if (32'(i_sin) < -ONE) n_ss = 26'(-ONE);
    end

    assign n_mxx = (52'(n_cc) * 52'(n_cc)) >>> FRAC_BITS;
    assign n_mxy = (52'(n_cc) * 52'(n_ss)) >>> FRAC_BITS;
    assign n_myy = (52'(n_ss) * 52'(n_ss)) >>> FRAC_BITS;

    // F1: structural tensor, latch tensor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0   <= MW'(n_mxx);
            r_m1   <= MW'(n_mxy);
            r_m2   <= MW'(n_myy);
            r_cxx  <= i_in.c_xx;
            r_cyy  <= i_in.c_yy;
            r_csum <= 33'(i_in.c_xy) + 33'(i_in.c_yx);
        end
    end

    assign n_pa = (64'(r_m0) * 64'(r_cxx)) >>> FRAC_BITS;
    assign n_pb = (66'(r_m1) * 66'(r_csum)) >>> FRAC_BITS;
    assign n_pc = (64'(r_m2) * 64'(r_cyy)) >>> FRAC_BITS;
    assign n_i  = 36'(r_pa) + 36'(r_pb) + 36'(r_pc) - 36'(ONE);

    assign n_t  = (64'(r_ic) * 64'(r_ic)) >>> FRAC_BITS;
    assign n_g  = (64'(i_gain) * 64'(r_ic)) >>> FRAC_BITS;
    assign n_xs = (r_xp >>> FRAC_BITS) - 64'(i_offs);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // F2: contraction products
            r_pa <= 34'(n_pa);
            r_pb <= 34'(n_pb);
            r_pc <= 34'(n_pc);
            // F3: fiber strain
            r_ic <= sat32(64'(n_i));
            r_f3 <= over32(64'(n_i));
            // F4: squared strain and gain term
            r_t  <= sat32(n_t);
            r_g4 <= sat32(n_g);
            r_f4 <= r_f3 | over32(n_t) | over32(n_g);
            // F5
            r_xp <= 64'(i_expo) * 64'(r_t);
            r_g5 <= r_g4;
            r_f5 <= r_f4;
            // F6: exponent argument, clamped
            if (n_xs > XLIM) begin
                r_x <= XW'(XLIM);
            end else if (n_xs < -XLIM) begin
                r_x <= XW'(-XLIM);
            end else begin
                r_x <= XW'(n_xs);
            end
            r_g6 <= r_g5;
            r_f6 <= r_f5 | (n_xs > XLIM) | (n_xs < -XLIM);
        end
    end

    tfes_exp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_exp (
        .i_clk(i_clk),
        .i_en (i_en),
        .i_x  (r_x),
        .o_e  (w_e),
        .o_sat(w_esat)
    );

    // gain term and flags ride alongside the exponential
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gd[0] <= r_g6;
            r_fd[0] <= r_f6;
            for (int k = 1; k < EXP_DEPTH; k++) begin
                r_gd[k] <= r_gd[k-1];
                r_fd[k] <= r_fd[k-1];
            end
        end
    end

    assign n_dw = (64'(r_gd[EXP_DEPTH-1]) * 64'(w_e)) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dw  <= sat32(n_dw);
            r_sat <= r_fd[EXP_DEPTH-1] | w_esat | over32(n_dw);
        end
    end

    // tensor only changes with configuration, which is idle-only
    assign o_m0  = r_m0;
    assign o_m1  = r_m1;
    assign o_m2  = r_m2;
    assign o_dw  = r_dw;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

// File: rtl/tfes_mix.sv
// Sums both families' weighted structural tensors into the saturated Q16.16 stress.
`default_nettype none

module tfes_mix #(
    parameter int FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [31:0]          i_dw1,
    input  logic signed [31:0]          i_dw2,
    input  logic signed [FRAC_BITS+1:0] i_m1 [3],
    input  logic signed [FRAC_BITS+1:0] i_m2 [3],
    input  logic                        i_sat1,
    input  logic                        i_sat2,
    output tfes_pkg::t_stress_out       o_out
);
    import tfes_pkg::*;

    localparam int SH = 2 * FRAC_BITS - 16;

    logic signed [63:0] r_p1 [3];
    logic signed [63:0] r_p2 [3];
    logic               r_f;
    logic signed [63:0] n_v [3];
    logic signed [31:0] r_s [3];
    logic               r_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_p1[j] <= 64'(i_dw1) * 64'(i_m1[j]);
                r_p2[j] <= 64'(i_dw2) * 64'(i_m2[j]);
            end
            r_f <= i_sat1 | i_sat2;
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_v[j] = (r_p1[j] + r_p2[j]) >>> SH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_s[j] <= sat32(n_v[j]);
            end
            r_sat <= r_f | over32(n_v[0]) | over32(n_v[1]) | over32(n_v[2]);
        end
    end

    assign o_out.s_xx      = r_s[0];
    assign o_out.s_shear   = r_s[1];
    assign o_out.s_yy      = r_s[2];
    assign o_out.saturated = r_sat;

endmodule

`default_nettype wire
